// File: sv/skf3_pkg.sv
// ----------------------------------------------------------------------------
// skf3_pkg: shared constants for the three-axis scalar Kalman filter
// Field widths, register indexes, reset values and serial loop lengths.
// ----------------------------------------------------------------------------
package skf3_pkg;

    // number of filter channels and the bits of a channel number
    localparam int AXES    = 3;
    localparam int AXIS_W  = 2;

    // Q16.16 data and configuration words
    localparam int DATA_W  = 32;

    // configuration register indexes
    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_PROCESS_NOISE     = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MEASUREMENT_NOISE = 2'd1;

    // reset values: Q about 0.02, R 8.0
    localparam logic [DATA_W-1:0] Q_RESET = 32'd1311;
    localparam logic [DATA_W-1:0] R_RESET = 32'd524288;

    // gain is unsigned Q0.16, saturated below 1.0
    localparam int GAIN_W = 16;
    localparam logic [GAIN_W-1:0] GAIN_MAX = 16'hFFFF;

    // serial loop lengths: quotient bits and multiplier bits
    localparam int DIV_STEPS = 17;
    localparam int MUL_STEPS = 17;
    localparam int CNT_W     = 5;

endpackage

// File: sv/scalar_kalman_filter_three_axis.sv
// ----------------------------------------------------------------------------
// scalar_kalman_filter_three_axis: per-axis 1-D Kalman update, bit serial
// One state slot per axis; restoring divider and shift-add multipliers
// each resolve one bit per cycle.
// ----------------------------------------------------------------------------
// Sequence: an accepted beat passes S_PM, S_DEN, S_NUM, S_DIV, S_GAIN, S_MUL
//   and S_FIN; an axis number out of range goes straight to S_FIN.
// Input: no new beat is taken until the update is done; most of it is the 17-step
//   serial divider for the gain and the 17-step shift-add multiplier loop after it.
// Reset: rst_n low clears estimates and covariances of every axis to zero and
//   loads Q = 1311 and R = 524288; the block leaves reset in the idle state.
module scalar_kalman_filter_three_axis
(
    input  logic                            clk,
    input  logic                            rst_n,
    // measurement channel
    input  logic                            meas_valid,
    output logic                            meas_stall,
    input  logic [skf3_pkg::AXIS_W-1:0]     axis,
    input  logic signed [skf3_pkg::DATA_W-1:0] measurement,
    // estimate channel
    output logic                            est_valid,
    input  logic                            est_stall,
    output logic [skf3_pkg::AXIS_W-1:0]     axis_out,
    output logic signed [skf3_pkg::DATA_W-1:0] estimate,
    // configuration write channel
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [skf3_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [skf3_pkg::DATA_W-1:0]     cfg_data
);
    import skf3_pkg::*;

    typedef enum logic [2:0]
    {
        S_IDLE,
        S_PM,
        S_DEN,
        S_NUM,
        S_DIV,
        S_GAIN,
        S_MUL,
        S_FIN
    } state_t;

    state_t                 state_reg;
    logic [CNT_W-1:0]       cnt_reg;

    // configuration and per-axis state
    logic [DATA_W-1:0]      q_reg;
    logic [DATA_W-1:0]      r_reg;
    logic [DATA_W-1:0]      est_reg [AXES];
    logic [DATA_W-1:0]      cov_reg [AXES];

    // working registers
    logic [AXIS_W-1:0]      axis_reg;
    logic                   axis_ok_reg;
    logic [DATA_W-1:0]      z_reg;
    logic [DATA_W-1:0]      x_reg;
    logic [DATA_W-1:0]      pm_reg;
    logic [DATA_W:0]        den_reg;
    logic [DATA_W:0]        rem_reg;
    logic [DIV_STEPS-1:0]   num_sh_reg;
    logic [DIV_STEPS-1:0]   quo_reg;
    logic [DATA_W:0]        diff_reg;
    logic [MUL_STEPS-1:0]   mul_g_reg;
    logic [MUL_STEPS-1:0]   mul_c_reg;
    logic [49:0]            acc_e_reg;
    logic [48:0]            acc_p_reg;

    // output register
    logic                   est_valid_reg;
    logic [AXIS_W-1:0]      axis_out_reg;
    logic [DATA_W-1:0]      estimate_reg;

    logic                   in_fire;
    logic                   out_free;
    logic [DATA_W:0]        cov_sum;
    logic [DATA_W-1:0]      pm_sat;
    logic [48:0]            num_full;
    logic [DATA_W+1:0]      trial;
    logic [GAIN_W-1:0]      gain;
    logic [49:0]            acc_e_add;
    logic [48:0]            acc_p_add;
    logic [49:0]            rnd_e;
    logic [34:0]            nx_wide;
    logic [DATA_W-1:0]      nx_sat;
    logic [48:0]            rnd_p;
    logic [DATA_W-1:0]      pn_sat;

    // config writes only between updates, and they go ahead of a new beat
    assign meas_stall = (state_reg != S_IDLE) || cfg_valid;
    assign cfg_ready  = (state_reg == S_IDLE);
    assign in_fire    = meas_valid && !meas_stall;
    assign out_free   = !est_valid_reg || !est_stall;

    assign est_valid  = est_valid_reg;
    assign axis_out   = axis_out_reg;
    assign estimate   = estimate_reg;

    // predicted covariance, saturated at the top of 32 bits
    assign cov_sum = {1'b0, cov_reg[axis_reg]} + {1'b0, q_reg};
    assign pm_sat  = cov_sum[DATA_W] ? {DATA_W{1'b1}} : cov_sum[DATA_W-1:0];

    // dividend pm*2^16 plus half the divisor for rounding
    assign num_full = {1'b0, pm_reg, 16'h0000} + {17'h00000, den_reg[DATA_W:1]};

    // restoring divider trial subtract
    assign trial = {rem_reg, num_sh_reg[DIV_STEPS-1]} - {1'b0, den_reg};

    // gain: zero for a zero divisor, saturated below one
    always_comb
    begin
        if (den_reg == '0)
            gain = '0;
        else if (quo_reg[DIV_STEPS-1])
            gain = GAIN_MAX;
        else
            gain = quo_reg[GAIN_W-1:0];
    end

    // shift-add partial products, MSB of the multiplier first
    assign acc_e_add = mul_g_reg[MUL_STEPS-1] ? {{17{diff_reg[DATA_W]}}, diff_reg} : '0;
    assign acc_p_add = mul_c_reg[MUL_STEPS-1] ? {17'h00000, pm_reg} : '0;

    // estimate rounding and saturation to signed 32 bits
    assign rnd_e   = acc_e_reg + 50'd32768;
    assign nx_wide = {{3{x_reg[DATA_W-1]}}, x_reg} + {rnd_e[49], rnd_e[49:16]};
    always_comb
    begin
        if (!nx_wide[34] && (nx_wide[33:31] != 3'b000))
            nx_sat = {1'b0, {(DATA_W-1){1'b1}}};
        else if (nx_wide[34] && (nx_wide[33:31] != 3'b111))
            nx_sat = {1'b1, {(DATA_W-1){1'b0}}};
        else
            nx_sat = nx_wide[DATA_W-1:0];
    end

    // covariance rounding and clip
    assign rnd_p  = acc_p_reg + 49'd32768;
    assign pn_sat = rnd_p[48] ? {DATA_W{1'b1}} : rnd_p[47:16];

    // state machine, datapath and registered outputs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            cnt_reg       <= '0;
            q_reg         <= Q_RESET;
            r_reg         <= R_RESET;
            for (int i = 0; i < AXES; i++)
            begin
                est_reg[i] <= '0;
                cov_reg[i] <= '0;
            end
            axis_reg      <= '0;
            axis_ok_reg   <= 1'b0;
            z_reg         <= '0;
            x_reg         <= '0;
            pm_reg        <= '0;
            den_reg       <= '0;
            rem_reg       <= '0;
            num_sh_reg    <= '0;
            quo_reg       <= '0;
            diff_reg      <= '0;
            mul_g_reg     <= '0;
            mul_c_reg     <= '0;
            acc_e_reg     <= '0;
            acc_p_reg     <= '0;
            est_valid_reg <= 1'b0;
            axis_out_reg  <= '0;
            estimate_reg  <= '0;
        end
        else
        begin
            // configuration writes; indexes past the list are dropped
            if (cfg_valid && cfg_ready)
            begin
                unique case (cfg_index)
                    CFG_PROCESS_NOISE:     q_reg <= cfg_data;
                    CFG_MEASUREMENT_NOISE: r_reg <= cfg_data;
                    default: ;
                endcase
            end

            // output beat taken; write-back loads the next one itself
            if (est_valid_reg && !est_stall && state_reg != S_FIN)
                est_valid_reg <= 1'b0;

            unique case (state_reg)
                S_IDLE:
                begin
                    if (in_fire)
                    begin
                        axis_reg    <= axis;
                        axis_ok_reg <= ({1'b0, axis} < (AXIS_W+1)'(AXES));
                        z_reg       <= measurement;
                        state_reg   <= ({1'b0, axis} < (AXIS_W+1)'(AXES)) ? S_PM : S_FIN;
                    end
                end
                S_PM:
                begin
                    x_reg     <= est_reg[axis_reg];
                    pm_reg    <= pm_sat;
                    state_reg <= S_DEN;
                end
                S_DEN:
                begin
                    den_reg   <= {1'b0, pm_reg} + {1'b0, r_reg};
                    state_reg <= S_NUM;
                end
                S_NUM:
                begin
                    rem_reg    <= {1'b0, num_full[48:17]};
                    num_sh_reg <= num_full[16:0];
                    quo_reg    <= '0;
                    cnt_reg    <= '0;
                    state_reg  <= S_DIV;
                end
                S_DIV:
                begin
                    // one quotient bit per cycle
                    if (!trial[DATA_W+1])
                        rem_reg <= trial[DATA_W:0];
                    else
                        rem_reg <= {rem_reg[DATA_W-1:0], num_sh_reg[DIV_STEPS-1]};
                    quo_reg    <= {quo_reg[DIV_STEPS-2:0], !trial[DATA_W+1]};
                    num_sh_reg <= {num_sh_reg[DIV_STEPS-2:0], 1'b0};
                    cnt_reg    <= cnt_reg + 1'b1;
                    if (cnt_reg == CNT_W'(DIV_STEPS-1))
                        state_reg <= S_GAIN;
                end
                S_GAIN:
                begin
                    diff_reg  <= {z_reg[DATA_W-1], z_reg} - {x_reg[DATA_W-1], x_reg};
                    mul_g_reg <= {1'b0, gain};
                    mul_c_reg <= 17'h10000 - {1'b0, gain};
                    acc_e_reg <= '0;
                    acc_p_reg <= '0;
                    cnt_reg   <= '0;
                    state_reg <= S_MUL;
                end
                S_MUL:
                begin
                    // gain*(z-x) and (1-gain)*pm, one multiplier bit per cycle
                    acc_e_reg <= {acc_e_reg[48:0], 1'b0} + acc_e_add;
                    acc_p_reg <= {acc_p_reg[47:0], 1'b0} + acc_p_add;
                    mul_g_reg <= {mul_g_reg[MUL_STEPS-2:0], 1'b0};
                    mul_c_reg <= {mul_c_reg[MUL_STEPS-2:0], 1'b0};
                    cnt_reg   <= cnt_reg + 1'b1;
                    if (cnt_reg == CNT_W'(MUL_STEPS-1))
                        state_reg <= S_FIN;
                end
                S_FIN:
                begin
                    // write back and present the result once the output is free
                    if (out_free)
                    begin
                        if (axis_ok_reg)
                        begin
                            est_reg[axis_reg] <= nx_sat;
                            cov_reg[axis_reg] <= pn_sat;
                        end
                        est_valid_reg <= 1'b1;
                        axis_out_reg  <= axis_reg;
                        estimate_reg  <= axis_ok_reg ? nx_sat : '0;
                        state_reg     <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    // divider remainder stays below the divisor
    a_rem_below_den: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DIV && den_reg != '0) |-> (rem_reg < den_reg))
        else $error("divider remainder not below divisor");

    // a result appears only out of the write-back state
    a_valid_from_fin: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(est_valid_reg) |-> $past(state_reg == S_FIN))
        else $error("result raised outside write-back");

    // an accepted beat closes the input until the update is done
    a_stall_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        in_fire |=> meas_stall)
        else $error("input not stalled after accept");

    // write-back with a free output always leaves a valid result
    a_fin_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_FIN && out_free) |=> (est_valid_reg && state_reg == S_IDLE))
        else $error("write-back did not produce a result");

    // multiplier loop count stays in range
    a_mul_count: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_MUL) |-> (cnt_reg < CNT_W'(MUL_STEPS)))
        else $error("multiplier step count out of range");

endmodule

// File: test/scalar_kalman_filter_three_axis_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// scalar_kalman_filter_three_axis_tb: self-checking bench for the 3-axis filter
// Drives measurement beats with random gaps and estimate-side stalls, walks a
// directed table of corner cases, then random phases under varying Q and R.
// Each beat is checked against a bit-accurate Q16.16 model or a typed value.
// ----------------------------------------------------------------------------
module scalar_kalman_filter_three_axis_tb;

    import skf3_pkg::*;

    // channel numbers; 3 is past the last axis and must be echoed with zero
    localparam logic [AXIS_W-1:0] AXIS_X    = 2'd0;
    localparam logic [AXIS_W-1:0] AXIS_Y    = 2'd1;
    localparam logic [AXIS_W-1:0] AXIS_Z    = 2'd2;
    localparam logic [AXIS_W-1:0] AXIS_NONE = 2'd3;

    // register index with no register behind it
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd3;

    // receiver long hold-off, to back the block up into the sender
    localparam int HOLD_AT     = 700;
    localparam int HOLD_CYCLES = 600;

    localparam int RAND_PHASES     = 10;
    localparam int ITEMS_PER_PHASE = 125;

    typedef struct packed {
        logic [AXIS_W-1:0] ch;
        logic [DATA_W-1:0] value;
    } est_beat_t;

    typedef enum logic {ROW_WRITE, ROW_SAMPLE} row_kind_t;

    // sel is the axis for a sample row, the register index for a write row
    typedef struct packed {
        row_kind_t         kind;
        logic [1:0]        sel;
        logic [DATA_W-1:0] data;
        logic              typed;
        logic [DATA_W-1:0] want;
    } plan_row_t;

    logic                     clk = 1'b0;
    logic                     rst_n = 1'b0;
    logic                     meas_valid = 1'b0;
    logic                     meas_stall;
    logic [AXIS_W-1:0]        axis = '0;
    logic signed [DATA_W-1:0] measurement = '0;
    logic                     est_valid;
    logic                     est_stall = 1'b0;
    logic [AXIS_W-1:0]        axis_out;
    logic signed [DATA_W-1:0] estimate;
    logic                     cfg_valid = 1'b0;
    logic                     cfg_ready;
    logic [CFG_IDX_W-1:0]     cfg_index = '0;
    logic [DATA_W-1:0]        cfg_data = '0;

    // filter model state and registers
    logic signed [DATA_W-1:0] axis_estimate [AXES];
    logic [DATA_W-1:0]        axis_covariance [AXES];
    logic [DATA_W-1:0]        q_noise;
    logic [DATA_W-1:0]        r_noise;

    est_beat_t pending_estimates [$];
    int        mismatches = 0;
    int        estimates_seen = 0;
    bit        src_idle = 1'b1;
    bit        sink_idle = 1'b1;

    // directed corner cases; typed rows carry an expectation read off by hand
    plan_row_t directed_plan [25] = '{
        // after reset, zero state and zero measurement give zero
        '{ROW_SAMPLE, AXIS_X,    32'h0000_0000, 1'b1, 32'h0000_0000},
        '{ROW_SAMPLE, AXIS_NONE, 32'h7FFF_FFFF, 1'b1, 32'h0000_0000},
        // Q = R = 0: untouched axes have a zero denominator, gain zero
        '{ROW_WRITE,  CFG_PROCESS_NOISE,     32'h0000_0000, 1'b0, 32'h0},
        '{ROW_WRITE,  CFG_MEASUREMENT_NOISE, 32'h0000_0000, 1'b0, 32'h0},
        '{ROW_SAMPLE, AXIS_Y,    32'h7FFF_FFFF, 1'b1, 32'h0000_0000},
        '{ROW_SAMPLE, AXIS_Z,    32'h8000_0000, 1'b1, 32'h0000_0000},
        // x has covariance left over, so R = 0 drives the gain to its cap
        '{ROW_SAMPLE, AXIS_X,    32'h4000_0000, 1'b0, 32'h0},
        '{ROW_SAMPLE, AXIS_X,    32'hC000_0000, 1'b0, 32'h0},
        // write to a missing register must not disturb anything
        '{ROW_WRITE,  CFG_SPARE,             32'hDEAD_BEEF, 1'b0, 32'h0},
        '{ROW_WRITE,  CFG_PROCESS_NOISE,     Q_RESET,       1'b0, 32'h0},
        '{ROW_WRITE,  CFG_MEASUREMENT_NOISE, R_RESET,       1'b0, 32'h0},
        // full-scale swings
        '{ROW_SAMPLE, AXIS_Y,    32'h7FFF_FFFF, 1'b0, 32'h0},
        '{ROW_SAMPLE, AXIS_Z,    32'h8000_0000, 1'b0, 32'h0},
        '{ROW_SAMPLE, AXIS_Y,    32'h8000_0000, 1'b0, 32'h0},
        '{ROW_SAMPLE, AXIS_Z,    32'hFFFF_FFFF, 1'b0, 32'h0},
        '{ROW_SAMPLE, AXIS_NONE, 32'h8000_0000, 1'b1, 32'h0000_0000},
        // max Q: predicted covariance saturates
        '{ROW_WRITE,  CFG_PROCESS_NOISE,     32'hFFFF_FFFF, 1'b0, 32'h0},
        '{ROW_SAMPLE, AXIS_X,    32'h7FFF_FFFF, 1'b0, 32'h0},
        '{ROW_SAMPLE, AXIS_Y,    32'h0000_0001, 1'b0, 32'h0},
        '{ROW_SAMPLE, AXIS_X,    32'h8000_0000, 1'b0, 32'h0},
        // max R too: widest denominator
        '{ROW_WRITE,  CFG_MEASUREMENT_NOISE, 32'hFFFF_FFFF, 1'b0, 32'h0},
        '{ROW_SAMPLE, AXIS_Z,    32'h5555_5555, 1'b0, 32'h0},
        '{ROW_SAMPLE, AXIS_X,    32'hAAAA_AAAA, 1'b0, 32'h0},
        '{ROW_SAMPLE, AXIS_Y,    32'h0001_0000, 1'b0, 32'h0},
        '{ROW_SAMPLE, AXIS_NONE, 32'h0000_0000, 1'b1, 32'h0000_0000}
    };

    scalar_kalman_filter_three_axis DUT
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .meas_valid  (meas_valid),
        .meas_stall  (meas_stall),
        .axis        (axis),
        .measurement (measurement),
        .est_valid   (est_valid),
        .est_stall   (est_stall),
        .axis_out    (axis_out),
        .estimate    (estimate),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // run limit, far beyond the slowest legal run
    initial
    begin
        #10_000_000;
        $display("FAIL");
        $finish;
    end

    task automatic report_mismatch(input string msg);
        if (mismatches < 100)
            $display("%0t ERROR %s", $time, msg);
        mismatches++;
    endtask

    // one Kalman step on the model; returns the beat the block should emit
    function automatic est_beat_t kalman_update(input logic [AXIS_W-1:0] ch,
                                                input logic signed [DATA_W-1:0] z);
        logic [DATA_W:0] pm_sum;
        logic [63:0]     pm;
        logic [63:0]     den;
        logic [63:0]     gain;
        logic [63:0]     cov_next;
        longint          diff;
        longint          corr;
        longint          x_next;
        est_beat_t       beat;

        beat.ch    = ch;
        beat.value = '0;
        if (ch >= AXES)
            return beat;

        // predicted covariance, saturating
        pm_sum = {1'b0, axis_covariance[ch]} + {1'b0, q_noise};
        pm     = pm_sum[DATA_W] ? 64'hFFFF_FFFF : 64'(pm_sum[DATA_W-1:0]);

        // gain pm / (pm + R), Q0.16 rounded, capped below one
        den = pm + 64'(r_noise);
        if (den == 0)
            gain = 0;
        else
        begin
            gain = ((pm << 16) + (den >> 1)) / den;
            if (gain > 64'(GAIN_MAX))
                gain = 64'(GAIN_MAX);
        end

        // estimate update, round half up, clamp to int32
        diff   = longint'(z) - longint'(axis_estimate[ch]);
        corr   = longint'(gain) * diff;
        x_next = longint'(axis_estimate[ch]) + ((corr + 64'sd32768) >>> 16);
        if (x_next > 64'sd2147483647)
            x_next = 64'sd2147483647;
        if (x_next < -64'sd2147483648)
            x_next = -64'sd2147483648;

        cov_next = ((64'd65536 - gain) * pm + 64'd32768) >> 16;
        if (cov_next > 64'hFFFF_FFFF)
            cov_next = 64'hFFFF_FFFF;

        axis_estimate[ch]   = 32'(x_next);
        axis_covariance[ch] = cov_next[DATA_W-1:0];
        beat.value          = 32'(x_next);
        return beat;
    endfunction

    // offer one measurement beat; predict its estimate once it is taken
    task automatic send_sample(input logic [AXIS_W-1:0] ch, input logic [DATA_W-1:0] z,
                               input logic typed, input logic [DATA_W-1:0] want);
        int unsigned gap;
        est_beat_t   predicted;

        gap = src_idle ? $urandom_range(0, 9) : 0;
        cfg_valid <= 1'b0;
        if (gap != 0)
        begin
            meas_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        meas_valid  <= 1'b1;
        axis        <= ch;
        measurement <= z;
        do @(posedge clk); while (meas_stall);
        predicted = kalman_update(ch, z);
        if (typed)
            predicted.value = want;
        pending_estimates.push_back(predicted);
    endtask

    // register write; valid stays up so back-to-back writes need no gap
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [DATA_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do @(posedge clk); while (!cfg_ready);
        case (idx)
            CFG_PROCESS_NOISE:     q_noise = data;
            CFG_MEASUREMENT_NOISE: r_noise = data;
            default: ;
        endcase
    endtask

    task automatic wait_drained();
        meas_valid <= 1'b0;
        while (pending_estimates.size() != 0)
            @(posedge clk);
    endtask

    // estimate side: random stalls, one long hold-off, in-order checking
    initial
    begin : estimate_sink
        int unsigned stall_cycles;
        est_beat_t   want;

        wait (rst_n);
        @(posedge clk);
        forever
        begin
            stall_cycles = sink_idle ? $urandom_range(0, 9) : 0;
            if (estimates_seen == HOLD_AT)
                stall_cycles = HOLD_CYCLES;
            if (stall_cycles != 0)
            begin
                est_stall <= 1'b1;
                repeat (stall_cycles) @(posedge clk);
            end
            est_stall <= 1'b0;
            do @(posedge clk); while (!est_valid);

            if (pending_estimates.size() == 0)
                report_mismatch($sformatf("unexpected beat: axis %0d estimate %h",
                                          axis_out, estimate));
            else
            begin
                want = pending_estimates.pop_front();
                if (axis_out !== want.ch)
                    report_mismatch($sformatf("beat %0d axis_out %0d, want %0d",
                                              estimates_seen, axis_out, want.ch));
                if (estimate !== want.value)
                    report_mismatch($sformatf("beat %0d axis %0d estimate %h, want %h",
                                              estimates_seen, want.ch, estimate, want.value));
            end
            estimates_seen++;
        end
    end

    // stimulus
    initial
    begin : stimulus
        logic [AXIS_W-1:0] ch;
        logic [DATA_W-1:0] z;
        logic [DATA_W-1:0] q_pick;
        logic [DATA_W-1:0] r_pick;

        // model matches the block's reset
        q_noise = Q_RESET;
        r_noise = R_RESET;
        for (int i = 0; i < AXES; i++)
        begin
            axis_estimate[i]   = '0;
            axis_covariance[i] = '0;
        end

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        // directed table
        foreach (directed_plan[i])
        begin
            if (directed_plan[i].kind == ROW_WRITE)
            begin
                wait_drained();
                write_reg(directed_plan[i].sel, directed_plan[i].data);
            end
            else
                send_sample(directed_plan[i].sel, directed_plan[i].data,
                            directed_plan[i].typed, directed_plan[i].want);
        end

        // random phases, each under its own noise setting
        for (int phase = 0; phase < RAND_PHASES; phase++)
        begin
            wait_drained();
            case (phase % 5)
                0: begin q_pick = Q_RESET;                   r_pick = R_RESET;                  end
                1: begin q_pick = $urandom_range(0, 262143); r_pick = $urandom_range(0, 1 << 22); end
                2: begin q_pick = $urandom;                  r_pick = $urandom;                 end
                3: begin q_pick = '0;                        r_pick = $urandom_range(0, 1 << 20); end
                default: begin q_pick = '1;                  r_pick = $urandom;                 end
            endcase
            write_reg(CFG_PROCESS_NOISE, q_pick);
            write_reg(CFG_MEASUREMENT_NOISE, r_pick);
            if ($urandom_range(0, 2) == 0)
                write_reg(CFG_SPARE, $urandom);

            // every fourth phase runs both sides flat out
            src_idle  = (phase % 4 != 1);
            sink_idle = (phase % 4 != 1);

            for (int n = 0; n < ITEMS_PER_PHASE; n++)
            begin
                ch = ($urandom_range(0, 9) == 0) ? AXIS_NONE : 2'($urandom_range(0, 2));
                case ($urandom_range(0, 9))
                    0: case ($urandom_range(0, 3))
                           0: z = 32'h7FFF_FFFF;
                           1: z = 32'h8000_0000;
                           2: z = 32'hFFFF_FFFF;
                           default: z = 32'h0000_0000;
                       endcase
                    1, 2, 3: z = $urandom;
                    // sensor-like: noise around the current estimate
                    default: z = (ch == AXIS_NONE) ? $urandom
                                 : axis_estimate[ch]
                                   + (int'($urandom_range(0, 1 << 20)) - (1 << 19));
                endcase
                send_sample(ch, z, 1'b0, '0);
            end
        end

        wait_drained();
        cfg_valid <= 1'b0;
        repeat (64) @(posedge clk);
        if (mismatches == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
